// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands with a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle check: property holds at every clock edge out of reset
`define ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle check: antecedent implies consequent at the next clock edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kgrp_pkg.sv =====
// ----------------------------------------------------------------------------
// kgrp_pkg
// Types, constants and table functions for the keyframe gate.
// ----------------------------------------------------------------------------
package kgrp_pkg;

  localparam logic [1:0] REG_DIST  = 2'd0;
  localparam logic [1:0] REG_ANGLE = 2'd1;

  localparam logic [30:0] DIST_RESET  = 31'd32768;
  localparam logic [14:0] ANGLE_RESET = 15'd2731;

  localparam logic signed [32:0] GAIN_Q24     = 33'sd10188014;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd16384;
  localparam logic signed [16:0] HALF_TURN    = 17'sd32768;
  localparam logic signed [59:0] ROUND_HALF   = 60'sd8388608;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_DIFF = 13'b0000000000010,
    S_ABS  = 13'b0000000000100,
    S_SQX  = 13'b0000000001000,
    S_SQY  = 13'b0000000010000,
    S_SQT  = 13'b0000000100000,
    S_DEC  = 13'b0000001000000,
    S_GX   = 13'b0000010000000,
    S_GY   = 13'b0000100000000,
    S_LDY  = 13'b0001000000000,
    S_ROT  = 13'b0010000000000,
    S_FIN  = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } kgrp_state_e;

  typedef logic signed [59:0] kgrp_acc_t;

  function automatic logic [31:0] kgrp_atan(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // round at bit 24 and saturate to 32-bit signed
  function automatic logic [31:0] kgrp_finish(input kgrp_acc_t v);
    kgrp_acc_t   t;
    logic [35:0] r;
    logic [31:0] o;
    t = v + ROUND_HALF;
    r = t[59:24];
    if (!r[35] && (r[34:31] != 4'b0000)) begin
      o = 32'h7FFF_FFFF;
    end else if (r[35] && (r[34:31] != 4'b1111)) begin
      o = 32'h8000_0000;
    end else begin
      o = r[31:0];
    end
    return o;
  endfunction

endpackage

// ===== rtl/keyframe_gate_relative_pose.sv =====
// ----------------------------------------------------------------------------
// keyframe_gate_relative_pose
// Keyframe selection by travel and turn, with the odometry edge from the
// previous keyframe rotated into its frame by an iterative CORDIC.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_stall_o   pose_x, pose_y, pose_heading
//  out      source     out_valid_o / out_stall_i keyframe_added .. edge_turn
//  cfg      sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  A word steps through DIFF, ABS, SQX, SQY, SQT and DEC to DONE; when an
//  edge is formed, GX, GY, LDY, ROT (once per CORDIC step) and FIN come between;
//  the shared multiplier sets this order. Input stalls for the whole item.
//  The finished word waits in an output register; the next word is taken
//  while it waits. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module keyframe_gate_relative_pose
  import kgrp_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pose_x_i,
  input  logic signed [31:0] pose_y_i,
  input  logic signed [15:0] pose_heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               keyframe_added_o,
  output logic [15:0]        keyframe_number_o,
  output logic               edge_valid_o,
  output logic signed [31:0] edge_forward_o,
  output logic signed [31:0] edge_lateral_o,
  output logic signed [15:0] edge_turn_o
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

  kgrp_state_e state_q, state_d;

  logic [30:0] dist_thr_q;
  logic [14:0] ang_thr_q;
  logic [31:0] anc_x_q, anc_y_q;
  logic [15:0] anc_h_q;
  logic        anc_present_q;
  logic [15:0] next_num_q;
  logic        out_valid_q;

  logic [31:0]        px_q, py_q;
  logic [15:0]        ph_q;
  logic signed [32:0] dx_q, dy_q;
  logic [15:0]        turn_q;
  logic [30:0]        ax_q, ay_q;
  logic               huge_q, ang_hit_q;
  logic [62:0]        acc_q;
  logic signed [65:0] prod_q;
  kgrp_acc_t          x_q, y_q;
  logic signed [33:0] z_q;
  logic [IW-1:0]      i_q;

  logic        res_added_q, res_edge_q;
  logic [15:0] res_num_q, res_turn_q;
  logic [31:0] res_fwd_q, res_lat_q;

  logic        out_added_q, out_edge_q;
  logic [15:0] out_num_q, out_turn_q;
  logic [31:0] out_fwd_q, out_lat_q;

  logic               in_take;
  logic               out_load;
  logic               take;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [32:0] ax_full, ay_full;
  logic [15:0]        tmag;
  logic signed [16:0] tgt, tgt_r;
  logic               flip;
  kgrp_acc_t          xs, ys;
  logic signed [33:0] atan_s;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign take = !anc_present_q || huge_q || ang_hit_q || (acc_q >= prod_q[62:0]);

  // shared multiplier
  always_comb begin
    unique case (state_q)
      S_SQX:   begin mul_a = {2'b00, ax_q};       mul_b = {2'b00, ax_q};       end
      S_SQY:   begin mul_a = {2'b00, ay_q};       mul_b = {2'b00, ay_q};       end
      S_SQT:   begin mul_a = {2'b00, dist_thr_q}; mul_b = {2'b00, dist_thr_q}; end
      S_GY:    begin mul_a = dy_q;                mul_b = GAIN_Q24;            end
      default: begin mul_a = dx_q;                mul_b = GAIN_Q24;            end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign ax_full = dx_q[32] ? -dx_q : dx_q;
  assign ay_full = dy_q[32] ? -dy_q : dy_q;
  assign tmag    = turn_q[15] ? 16'(-turn_q) : turn_q;

  always_comb begin
    tgt   = -{anc_h_q[15], anc_h_q};
    flip  = 1'b0;
    tgt_r = tgt;
    if (tgt > QUARTER_TURN) begin
      flip  = 1'b1;
      tgt_r = tgt - HALF_TURN;
    end else if (tgt < -QUARTER_TURN) begin
      flip  = 1'b1;
      tgt_r = tgt + HALF_TURN;
    end
  end

  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;
  assign atan_s = {2'b00, kgrp_atan(5'(i_q))};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_take) state_d = S_DIFF;
      S_DIFF:  state_d = S_ABS;
      S_ABS:   state_d = S_SQX;
      S_SQX:   state_d = S_SQY;
      S_SQY:   state_d = S_SQT;
      S_SQT:   state_d = S_DEC;
      S_DEC:   state_d = (take && anc_present_q) ? S_GX : S_DONE;
      S_GX:    state_d = S_GY;
      S_GY:    state_d = S_LDY;
      S_LDY:   state_d = S_ROT;
      S_ROT:   if (i_q == LAST_STEP) state_d = S_FIN;
      S_FIN:   state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      dist_thr_q    <= DIST_RESET;
      ang_thr_q     <= ANGLE_RESET;
      anc_x_q       <= '0;
      anc_y_q       <= '0;
      anc_h_q       <= '0;
      anc_present_q <= 1'b0;
      next_num_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DIST:  dist_thr_q <= cfg_data_i;
          REG_ANGLE: ang_thr_q  <= cfg_data_i[14:0];
          default:   ;
        endcase
      end
      if ((state_q == S_DEC) && take) begin
        anc_x_q       <= px_q;
        anc_y_q       <= py_q;
        anc_h_q       <= ph_q;
        anc_present_q <= 1'b1;
        next_num_q    <= next_num_q + 16'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          px_q <= pose_x_i;
          py_q <= pose_y_i;
          ph_q <= pose_heading_i;
        end
      end
      S_DIFF: begin
        dx_q   <= $signed({px_q[31], px_q}) - $signed({anc_x_q[31], anc_x_q});
        dy_q   <= $signed({py_q[31], py_q}) - $signed({anc_y_q[31], anc_y_q});
        turn_q <= ph_q - anc_h_q;
      end
      S_ABS: begin
        ax_q      <= ax_full[30:0];
        ay_q      <= ay_full[30:0];
        huge_q    <= ax_full[32] | ax_full[31] | ay_full[32] | ay_full[31];
        ang_hit_q <= (tmag >= {1'b0, ang_thr_q});
      end
      S_SQY: acc_q <= prod_q[62:0];
      S_SQT: acc_q <= acc_q + prod_q[62:0];
      S_DEC: begin
        res_added_q <= take;
        res_num_q   <= take ? next_num_q : 16'd0;
        res_edge_q  <= take && anc_present_q;
        res_turn_q  <= (take && anc_present_q) ? turn_q : 16'd0;
        res_fwd_q   <= '0;
        res_lat_q   <= '0;
        z_q         <= {tgt_r[16], tgt_r, 16'b0};
        if (flip) begin
          dx_q <= -dx_q;
          dy_q <= -dy_q;
        end
      end
      S_GY:  x_q <= prod_q[59:0];
      S_LDY: begin
        y_q <= prod_q[59:0];
        i_q <= '0;
      end
      S_ROT: begin
        if (!z_q[33]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_s;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_s;
        end
        i_q <= i_q + IW'(1);
      end
      S_FIN: begin
        res_fwd_q <= kgrp_finish(x_q);
        res_lat_q <= kgrp_finish(y_q);
      end
      default: ;
    endcase
    if (out_load) begin
      out_added_q <= res_added_q;
      out_num_q   <= res_num_q;
      out_edge_q  <= res_edge_q;
      out_fwd_q   <= res_fwd_q;
      out_lat_q   <= res_lat_q;
      out_turn_q  <= res_turn_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign keyframe_added_o  = out_added_q;
  assign keyframe_number_o = out_num_q;
  assign edge_valid_o      = out_edge_q;
  assign edge_forward_o    = out_fwd_q;
  assign edge_lateral_o    = out_lat_q;
  assign edge_turn_o       = out_turn_q;

`include "assert_macros.svh"

  `ASSERT_NOW(a_edge_needs_key, clk_i, rst_ni, !out_valid_o || !edge_valid_o || keyframe_added_o, "edge without keyframe")
  `ASSERT_NEXT(a_id_advance, clk_i, rst_ni, (state_q == S_DEC) && take, next_num_q == 16'($past(next_num_q) + 16'd1), "keyframe id did not advance")
  `ASSERT_NOW(a_anchor_set, clk_i, rst_ni, !((state_q == S_DONE) && res_added_q) || anc_present_q, "keyframe without anchor")
  `ASSERT_NOW(a_rot_has_edge, clk_i, rst_ni, !((state_q == S_ROT) || (state_q == S_FIN)) || (res_added_q && res_edge_q), "rotation without edge")

endmodule
